// File: rtl/core/sfed_pkg.sv
// shared types and constants of the stereo feedback echo block
`default_nettype none

package sfed_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 8'd0,
    REG_FEEDBACK_GAIN = 8'd1,
    REG_DRY_GAIN      = 8'd2,
    REG_WET_GAIN      = 8'd3
  } reg_idx_t;

  localparam logic [DELAY_W-1:0] DELAY_LENGTH_RST  = 16'd24000;
  localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST = 16'd24576;
  localparam logic [GAIN_W-1:0]  DRY_GAIN_RST      = 16'd26214;
  localparam logic [GAIN_W-1:0]  WET_GAIN_RST      = 16'd16384;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  typedef struct packed {
    gain_t feedback;
    gain_t dry;
    gain_t wet;
  } gains_t;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/sfed_ifs.sv
// channel interfaces of the stereo feedback echo block
`default_nettype none

interface sfed_in_if import sfed_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfed_out_if import sfed_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sfed_cfg_if import sfed_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/stereo_feedback_echo_delay.sv
// top level of the stereo feedback echo: registers, front, queue and back
//
// channels: in_ch takes one stereo pair of q1.15 samples per transaction,
// out_ch gives one mixed pair per input transaction in the same order, and
// cfg_ch writes one 16-bit register per transaction (0 delay_length,
// 1 feedback_gain, 2 dry_gain, 3 wet_gain; other indexes are dropped).
// cfg_ch is always ready; it is to be written only while the block is
// idle, which the block itself does not enforce.
// path: the queue is written at the transaction, then line read,
// multiply, and round and mix into the output register.
// throughput: one pair per cycle while out_ch is ready, for a delay of 3
// samples or more; for a delay of 1 or 2 the line read waits on the
// feedback write of the pair that it reads, set by the read-after-write
// distance between the read and the mix stages around the line memory.
// reset: control state clears, registers take their defaults, and the
// lines read as zero until written, tracked from the write position and
// a wrap flag, so there is no clearing pass and the block is ready at once.
// stall: when out_ch is not ready the back pipeline holds, the 4-entry
// queue keeps taking pairs, and in_ch drops ready only once it is full.

`default_nettype none

module stereo_feedback_echo_delay import sfed_pkg::*; #(
  parameter int MAX_DELAY = 65536
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sfed_in_if.sink   in_ch,
  sfed_out_if.source out_ch,
  sfed_cfg_if.sink  cfg_ch
);

  localparam int AW      = $clog2(MAX_DELAY);
  localparam int ENTRY_W = 2 * SAMPLE_W + 2 * AW + 1;

  logic [DELAY_W-1:0] delay_length_r;
  gains_t             gains_r;

  logic               q_push, q_pop;
  logic [ENTRY_W-1:0] q_push_data, q_head_data;
  queue_stat_t        q_stat;

  // register file, written one transaction at a time
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_length_r   <= DELAY_LENGTH_RST;
      gains_r.feedback <= FEEDBACK_GAIN_RST;
      gains_r.dry      <= DRY_GAIN_RST;
      gains_r.wet      <= WET_GAIN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DELAY_LENGTH:  delay_length_r   <= cfg_ch.data;
        REG_FEEDBACK_GAIN: gains_r.feedback <= cfg_ch.data;
        REG_DRY_GAIN:      gains_r.dry      <= cfg_ch.data;
        REG_WET_GAIN:      gains_r.wet      <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // front: accept pairs, compute write and tail addresses
  sfed_front #(.MAX_DELAY(MAX_DELAY)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .delay_length (delay_length_r),
    .q_stat       (q_stat),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  // decoupling queue
  sfed_queue #(.W(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head_data),
    .stat      (q_stat)
  );

  // back: line memories, feedback write and dry/wet mix
  sfed_back #(.MAX_DELAY(MAX_DELAY)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_data (q_head_data),
    .pop       (q_pop),
    .gains     (gains_r),
    .out_ch    (out_ch)
  );

  // queue occupancy follows pushes and pops
  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> q_stat.count == QCNT_W'($past(q_stat.count) + QCNT_W'($past(q_push))
                                       - QCNT_W'($past(q_pop))))
    else $error("queue count out of step with push and pop");

  // the back only takes an entry the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // no result right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// File: rtl/core/sfed_queue.sv
// short fifo between the front and the back of the echo block
`default_nettype none

module sfed_queue import sfed_pkg::*; #(
  parameter int W = 65
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      head_data,
  output queue_stat_t       stat
);

  logic [W-1:0]      entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wptr_nxt = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

  assign head_data  = entry_r[rptr_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.count = cnt_r;

endmodule

`default_nettype wire

// File: rtl/core/sfed_front.sv
// input side: accepts sample pairs and works out line addresses
`default_nettype none

module sfed_front import sfed_pkg::*; #(
  parameter int MAX_DELAY = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sfed_in_if.sink                   in_ch,
  input  wire logic [DELAY_W-1:0]   delay_length,
  input  wire queue_stat_t          q_stat,
  output logic                      push,
  output logic [2*SAMPLE_W+2*$clog2(MAX_DELAY):0] push_data
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int LW = AW + 1;
  localparam int CW = (LW > DELAY_W) ? LW : DELAY_W;

  logic [AW-1:0] wr_r, wr_nxt;
  logic          wrap_r, wrap_nxt;
  logic [CW-1:0] d_ext, eff;
  logic [LW-1:0] eff_n, wr_ext;
  logic [AW-1:0] rd;
  logic          tail_ok;
  logic          at_end;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // zero or too long a delay means a whole line
  always_comb begin
    d_ext  = CW'(delay_length);
    eff    = ((d_ext == '0) || (d_ext > CW'(MAX_DELAY))) ? CW'(MAX_DELAY) : d_ext;
    eff_n  = eff[LW-1:0];
    wr_ext = {1'b0, wr_r};
    if (wr_ext >= eff_n) begin
      rd = AW'(wr_ext - eff_n);
    end else begin
      rd = AW'(wr_ext + LW'(MAX_DELAY) - eff_n);
    end
    // entry holds real data once written since reset
    tail_ok = wrap_r || (rd < wr_r);
  end

  always_comb begin
    at_end   = (wr_r == AW'(MAX_DELAY - 1));
    wr_nxt   = wr_r;
    wrap_nxt = wrap_r;
    if (push) begin
      wr_nxt   = at_end ? '0 : wr_r + 1'b1;
      wrap_nxt = wrap_r || at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      wrap_r <= 1'b0;
    end else begin
      wr_r   <= wr_nxt;
      wrap_r <= wrap_nxt;
    end
  end

  assign push_data = {in_ch.left_in, in_ch.right_in, wr_r, rd, tail_ok};

endmodule

`default_nettype wire

// File: rtl/core/sfed_back.sv
// execution side: delay line memories, gain multiplies and output register
`default_nettype none

module sfed_back import sfed_pkg::*; #(
  parameter int MAX_DELAY = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire queue_stat_t          q_stat,
  input  wire logic [2*SAMPLE_W+2*$clog2(MAX_DELAY):0] head_data,
  output logic                      pop,
  input  wire gains_t               gains,
  sfed_out_if.source                out_ch
);

  localparam int AW = $clog2(MAX_DELAY);

  sample_t       mem_l [MAX_DELAY];
  sample_t       mem_r [MAX_DELAY];

  sample_t       h_left, h_right;
  logic [AW-1:0] h_wr, h_rd;
  logic          h_ok;
  logic          adv, hazard;

  // read stage
  logic          s1_v_r;
  sample_t       s1_xl_r, s1_xr_r;
  logic [AW-1:0] s1_wr_r;
  logic          s1_ok_r;
  sample_t       rdata_l_r, rdata_r_r;
  sample_t       tail_l, tail_r;
  logic signed [GAIN_W:0] fbg, dryg, wetg;

  // mix stage
  logic               s2_v_r;
  sample_t            s2_xl_r, s2_xr_r;
  logic [AW-1:0]      s2_wr_r;
  logic signed [31:0] pfb_l_r, pfb_r_r, pdry_l_r, pdry_r_r, pwet_l_r, pwet_r_r;
  logic signed [32:0] fbs_l, fbs_r, outs_l, outs_r;
  sample_t            fb_l, fb_r, mix_l, mix_r;

  logic    out_valid_r;
  sample_t out_l_r, out_r_r;

  // q30 value already biased by one half, floor to q15 then clamp
  function automatic sample_t round_sat(input logic signed [32:0] s);
    logic signed [17:0] q;
    q = s[32:15];
    if (q > 18'sd32767) begin
      return 16'sh7fff;
    end else if (q < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  // signed sample times non-negative gain, full product in 32 bits
  function automatic logic signed [31:0] mul_gain(input sample_t x,
                                                  input logic signed [GAIN_W:0] g);
    logic signed [31:0] xe;
    logic signed [31:0] ge;
    xe = 32'(x);
    ge = 32'(g);
    return xe * ge;
  endfunction

  assign {h_left, h_right, h_wr, h_rd, h_ok} = head_data;

  assign adv = !out_valid_r || out_ch.ready;
  // wait while the entry to read still has a feedback write in flight
  assign hazard = (s1_v_r && (s1_wr_r == h_rd)) || (s2_v_r && (s2_wr_r == h_rd));
  assign pop    = q_stat.valid && !hazard && adv;

  always_comb begin
    fbg    = $signed({1'b0, gains.feedback});
    dryg   = $signed({1'b0, gains.dry});
    wetg   = $signed({1'b0, gains.wet});
    tail_l = s1_ok_r ? rdata_l_r : '0;
    tail_r = s1_ok_r ? rdata_r_r : '0;
  end

  always_comb begin
    fbs_l  = {{2{s2_xl_r[SAMPLE_W-1]}}, s2_xl_r, 15'd0} + {pfb_l_r[31], pfb_l_r}
             + 33'sd16384;
    fbs_r  = {{2{s2_xr_r[SAMPLE_W-1]}}, s2_xr_r, 15'd0} + {pfb_r_r[31], pfb_r_r}
             + 33'sd16384;
    outs_l = {pdry_l_r[31], pdry_l_r} + {pwet_l_r[31], pwet_l_r} + 33'sd16384;
    outs_r = {pdry_r_r[31], pdry_r_r} + {pwet_r_r[31], pwet_r_r} + 33'sd16384;
    fb_l   = round_sat(fbs_l);
    fb_r   = round_sat(fbs_r);
    mix_l  = round_sat(outs_l);
    mix_r  = round_sat(outs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= pop;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xl_r  <= h_left;
      s1_xr_r  <= h_right;
      s1_wr_r  <= h_wr;
      s1_ok_r  <= h_ok;
      s2_xl_r  <= s1_xl_r;
      s2_xr_r  <= s1_xr_r;
      s2_wr_r  <= s1_wr_r;
      pfb_l_r  <= mul_gain(tail_l, fbg);
      pfb_r_r  <= mul_gain(tail_r, fbg);
      pdry_l_r <= mul_gain(s1_xl_r, dryg);
      pdry_r_r <= mul_gain(s1_xr_r, dryg);
      pwet_l_r <= mul_gain(tail_l, wetg);
      pwet_r_r <= mul_gain(tail_r, wetg);
      out_l_r  <= mix_l;
      out_r_r  <= mix_r;
    end
  end

  // line memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (pop) begin
      rdata_l_r <= mem_l[h_rd];
      rdata_r_r <= mem_r[h_rd];
    end
    if (adv && s2_v_r) begin
      mem_l[s2_wr_r] <= fb_l;
      mem_r[s2_wr_r] <= fb_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_l_r;
  assign out_ch.right_out = out_r_r;

endmodule

`default_nettype wire

// File: tb/tb_stereo_feedback_echo_delay.sv
// testbench of the stereo feedback echo: directed and random pairs checked against a line model
module tb_stereo_feedback_echo_delay;
  timeunit 1ns;
  timeprecision 1ps;

  import sfed_pkg::*;

  // the block is built with its default line length, so a 16-bit position wraps the line
  localparam int LINE_DEPTH   = 65536;
  localparam int PIPE_LATENCY = 4;
  localparam int IDLE_LIMIT   = 3000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PAIRS = 1700;
  localparam int BACKLOG_PAIRS = 40;
  localparam int RX_HOLD      = 300;

  // indexes that hit no register
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LOW  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HIGH = 8'hFF;

  localparam sample_t SAMPLE_MAX = 16'h7FFF;
  localparam sample_t SAMPLE_MIN = 16'h8000;
  localparam gain_t   GAIN_ZERO  = 16'd0;
  localparam gain_t   GAIN_UNITY = 16'd32768;
  localparam gain_t   GAIN_MAX   = 16'hFFFF;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  logic clk;
  logic rst_n;

  sfed_in_if  in_ch ();
  sfed_out_if out_ch ();
  sfed_cfg_if cfg_ch ();

  stereo_feedback_echo_delay u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // echo model state: both delay lines, the write position and the registers
  // ---------------------------------------------------------------------------
  sample_t            left_line  [LINE_DEPTH];
  sample_t            right_line [LINE_DEPTH];
  logic [DELAY_W-1:0] wr_pos;
  logic [DELAY_W-1:0] echo_delay;
  gain_t              fb_gain;
  gain_t              dry_gain;
  gain_t              wet_gain;

  // mixed pairs still owed by the block, oldest first
  pair_t mix_expect_q [$];

  int unsigned bad_count      = 0;
  int unsigned report_count   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // q30 to q15: add half an lsb, floor by arithmetic shift, clip to 16 bits
  function automatic sample_t round_sat_q30(input longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> 15;
    if (q > 32767) return SAMPLE_MAX;
    if (q < -32768) return SAMPLE_MIN;
    return sample_t'(q);
  endfunction

  // one stereo step of the echo: read tails, write feedback, return the mix
  function automatic pair_t advance_echo(input sample_t xl, input sample_t xr);
    logic [DELAY_W-1:0] rd_pos;
    sample_t            tail_l;
    sample_t            tail_r;
    pair_t              mix;
    // delay 0 wraps to the full line length: the tail is the entry about to be overwritten
    rd_pos = wr_pos - echo_delay;
    tail_l = left_line[rd_pos];
    tail_r = right_line[rd_pos];
    // tails are read before the write so a full-length delay sees the old entry
    left_line[wr_pos]  = round_sat_q30(longint'(xl) * 32768 + longint'(tail_l) * longint'(fb_gain));
    right_line[wr_pos] = round_sat_q30(longint'(xr) * 32768 + longint'(tail_r) * longint'(fb_gain));
    mix.left  = round_sat_q30(longint'(xl) * longint'(dry_gain) +
                              longint'(tail_l) * longint'(wet_gain));
    mix.right = round_sat_q30(longint'(xr) * longint'(dry_gain) +
                              longint'(tail_r) * longint'(wet_gain));
    wr_pos = wr_pos + 1'b1;
    return mix;
  endfunction

  function automatic void note_failure(input string what, input pair_t want, input pair_t got);
    bad_count++;
    if (report_count < REPORT_LIMIT) begin
      report_count++;
      $display("%s: expected left %0d right %0d, got left %0d right %0d", what,
               $signed(want.left), $signed(want.right), $signed(got.left), $signed(got.right));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: samples every channel at the rising edge, feeds the model,
  // checks results in order and watches for a stuck run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pair_t got;
    pair_t want;
    bit    moved;
    moved = 1'b0;
    if (rst_n) begin
      // the result path goes first; a same-edge input is always younger
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        got.left  = out_ch.left_out;
        got.right = out_ch.right_out;
        if (mix_expect_q.size() == 0) begin
          note_failure("result with no pair pending", '0, got);
        end else begin
          want = mix_expect_q.pop_front();
          if (got.left !== want.left || got.right !== want.right) begin
            note_failure("mix mismatch", want, got);
          end
        end
      end
      // register writes, unknown indexes are dropped
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_ch.index)
          REG_DELAY_LENGTH:  echo_delay = cfg_ch.data;
          REG_FEEDBACK_GAIN: fb_gain    = cfg_ch.data;
          REG_DRY_GAIN:      dry_gain   = cfg_ch.data;
          REG_WET_GAIN:      wet_gain   = cfg_ch.data;
          default: ;
        endcase
      end
      // every accepted pair owes exactly one mixed pair
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        mix_expect_q.push_back(advance_echo(in_ch.left_in, in_ch.right_in));
      end
    end
    // watchdog on cycles with no transaction anywhere
    if (moved || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus a long hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 20) stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one pair after an optional gap and hold it until the transaction
  task automatic send_pair(input sample_t l, input sample_t r);
    int unsigned gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 99) < 25) gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (mix_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic set_echo(input logic [DELAY_W-1:0] delay, input gain_t fb, input gain_t dry,
                          input gain_t wet);
    wait_drained();
    write_reg(REG_DELAY_LENGTH, delay);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_DRY_GAIN, dry);
    write_reg(REG_WET_GAIN, wet);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return DELAY_W'($urandom_range(1, 3));
    if (r < 55) return DELAY_W'($urandom_range(64, 400));
    if (r < 70) return DELAY_W'($urandom_range(401, 4000));
    if (r < 78) return '0;
    if (r < 86) return 16'hFFFF;
    return DELAY_W'($urandom_range(64, 65535));
  endfunction

  function automatic gain_t pick_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return GAIN_ZERO;
    if (r < 24) return GAIN_UNITY;
    if (r < 32) return GAIN_MAX;
    if (r < 40) return gain_t'($urandom_range(32769, 65535));
    return gain_t'($urandom_range(0, 32768));
  endfunction

  function automatic sample_t pick_sample();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 8) return SAMPLE_MAX;
    if (r < 16) return SAMPLE_MIN;
    if (r < 22) return '0;
    if (r < 27) return '1;
    if (r < 45) begin
      v = int'($urandom_range(0, 1023)) - 512;
      return sample_t'(v);
    end
    return sample_t'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default registers right after reset: long delay, lines read as zero
  task automatic test_reset_defaults();
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, '1);
    send_pair(16'sd1, '0);
  endtask

  // every gain above one, delay of one sample: saturation on both paths
  task automatic test_gain_above_one();
    set_echo(16'd1, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, '0);
  endtask

  // delays of two and three, impulse then silence to watch the echo ring
  task automatic test_short_delays();
    set_echo(16'd2, GAIN_UNITY, GAIN_ZERO, GAIN_UNITY);
    send_pair(16'sd16384, -16'sd16384);
    repeat (5) send_pair('0, '0);
    set_echo(16'd3, GAIN_ZERO, GAIN_UNITY, GAIN_ZERO);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(-16'sd3, 16'sd3);
    send_pair('0, '0);
  endtask

  // writes to indexes past the register file change nothing
  task automatic test_unknown_register();
    wait_drained();
    write_reg(IDX_UNUSED_LOW, 16'hFFFF);
    write_reg(IDX_UNUSED_HIGH, 16'h0000);
    send_pair(16'sd1000, -16'sd1000);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, '0);
  endtask

  // delay 0 means the whole line
  task automatic test_zero_delay();
    set_echo('0, FEEDBACK_GAIN_RST, DRY_GAIN_RST, WET_GAIN_RST);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(16'sd77, -16'sd77);
  endtask

  // phases of random settings, each with a burst of random pairs
  task automatic test_random_mix();
    int unsigned sent;
    int unsigned phase_len;
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      set_echo(pick_delay(), pick_gain(), pick_gain(), pick_gain());
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) send_pair(pick_sample(), pick_sample());
      sent += phase_len;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // result side held off for a long stretch while pairs keep coming:
  // the internal queue fills and the input must stall without losing data
  task automatic test_output_backlog();
    set_echo(16'd64, pick_gain(), pick_gain(), pick_gain());
    rx_hold_cycles = RX_HOLD;
    tx_steady = 1'b1;
    repeat (BACKLOG_PAIRS) send_pair(pick_sample(), pick_sample());
    tx_steady = 1'b0;
    // sender pauses until every owed result is out
    wait_drained();
  endtask

  initial begin : stimulus
    int i;
    // model starts from the reset state: lines clear, defaults in the registers
    for (i = 0; i < LINE_DEPTH; i++) begin
      left_line[i]  = '0;
      right_line[i] = '0;
    end
    wr_pos     = '0;
    echo_delay = DELAY_LENGTH_RST;
    fb_gain    = FEEDBACK_GAIN_RST;
    dry_gain   = DRY_GAIN_RST;
    wet_gain   = WET_GAIN_RST;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_gain_above_one();
    test_short_delays();
    test_unknown_register();
    test_zero_delay();
    test_random_mix();
    test_output_backlog();

    wait_drained();
    // wait on to catch any stray result
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mix_expect_q.size() != 0) bad_count++;
    if (bad_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
